### hw/rtl/wdep_pkg.sv
// Shared constants, codes and handshake structs of the weighted-degree edge priority block.
// Used by the controller, the datapath and the top level; depends on nothing else.
package wdep_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int MAX_WEIGHT   = 64;
  localparam int MAX_DEGREE   = 4095;

  localparam int VTX_W      = 6;
  localparam int EIDX_W     = 8;
  localparam int ECNT_W     = 9;
  localparam int WGT_W      = 7;
  localparam int DEG_W      = 12;
  localparam int BKT_DEPTH  = MAX_DEGREE + 1;
  localparam int BCNT_W     = 7;
  localparam int PRI_W      = 13;
  localparam int VCNT_W     = 7;
  localparam int VCNT_RESET = 64;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_ADJUST = 2'd2,
    FUNC_SELECT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EDGE_RD,
    S_VTX_RD,
    S_CHECK,
    S_BKT_RD,
    S_BKT_WR,
    S_CLR,
    S_CLR_WAIT,
    S_CLR_FIN,
    S_SEL,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [WGT_W-1:0] weight;
    logic [VTX_W-1:0] second;
    logic [VTX_W-1:0] first;
  } edge_t;

  typedef struct packed {
    logic accept;
    logic init_wr;
    logic clr_rd;
    logic clr_fin;
    logic vtx_rd;
    logic check;
    logic bkt_rd;
    logic bkt_wr;
    logic scan_issue;
    logic done;
  } wdep_cmd_t;

  typedef struct packed {
    logic init_last;
    logic clr_last;
    logic err;
    logic no_change;
    logic step_last;
    logic sel_empty;
    logic scan_last;
    logic scan_busy;
    logic out_free;
  } wdep_stat_t;

endpackage

### hw/rtl/wdep_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the edge table, vertex degrees and degree bucket counts.
module wdep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/wdep_ctrl.sv
// Sequencing state machine of the weighted-degree edge priority block.
// Depends on wdep_pkg; drives commands into wdep_dp and reads its status.
module wdep_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  wdep_pkg::func_t     in_func,
  input  wdep_pkg::wdep_stat_t stat,
  output logic                in_ready,
  output wdep_pkg::wdep_cmd_t cmd
);

  import wdep_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (stat.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            FUNC_CLEAR:  state_next = S_CLR;
            FUNC_ADD:    state_next = S_VTX_RD;
            FUNC_ADJUST: state_next = S_EDGE_RD;
            FUNC_SELECT: state_next = stat.sel_empty ? S_DONE : S_SEL;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_EDGE_RD:  state_next = S_VTX_RD;
      S_VTX_RD:   state_next = S_CHECK;
      S_CHECK: begin
        state_next = (stat.err || stat.no_change) ? S_DONE : S_BKT_RD;
      end
      S_BKT_RD:   state_next = S_BKT_WR;
      S_BKT_WR: begin
        state_next = stat.step_last ? S_DONE : S_BKT_RD;
      end
      S_CLR: begin
        if (stat.clr_last) state_next = S_CLR_WAIT;
      end
      S_CLR_WAIT: state_next = S_CLR_FIN;
      S_CLR_FIN:  state_next = S_DONE;
      S_SEL: begin
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.scan_busy) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_INIT:     cmd.init_wr = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_EDGE_RD:  ;
      S_VTX_RD:   cmd.vtx_rd = 1'b1;
      S_CHECK:    cmd.check = 1'b1;
      S_BKT_RD:   cmd.bkt_rd = 1'b1;
      S_BKT_WR:   cmd.bkt_wr = 1'b1;
      S_CLR:      cmd.clr_rd = 1'b1;
      S_CLR_WAIT: ;
      S_CLR_FIN:  cmd.clr_fin = 1'b1;
      S_SEL:      cmd.scan_issue = 1'b1;
      S_DRAIN:    ;
      S_DONE:     cmd.done = stat.out_free;
      default:    ;
    endcase
  end

endmodule

### hw/rtl/wdep_dp.sv
// Datapath: edge table, vertex degree and bucket count memories, the select scan pipeline
// and the output register. Depends on wdep_pkg and wdep_ram; commanded by wdep_ctrl.
module wdep_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  wdep_pkg::wdep_cmd_t                cmd,
  output wdep_pkg::wdep_stat_t               stat,
  input  logic                               cfg_valid,
  input  logic [wdep_pkg::VCNT_W-1:0]        cfg_data,
  input  wdep_pkg::func_t                    in_func,
  input  logic [wdep_pkg::IN_DATA_W-1:0]     in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic [wdep_pkg::OUT_DATA_W-1:0]    out_data
);

  import wdep_pkg::*;

  localparam int SUM_W = DEG_W + 2;
  localparam int SWP_W = $clog2(BKT_DEPTH);
  localparam int PAD_W = OUT_DATA_W - PRI_W - EIDX_W - WGT_W;

  logic [VTX_W-1:0]  in_a;
  logic [VTX_W-1:0]  in_b;
  logic [EIDX_W-1:0] in_ei;
  logic [WGT_W-1:0]  in_w;

  logic [VCNT_W-1:0] vertex_count;
  logic [VCNT_W-1:0] active;
  logic [VCNT_W-1:0] n_new;

  func_t             func_r;
  logic [VTX_W-1:0]  v0;
  logic [VTX_W-1:0]  v1;
  logic [WGT_W-1:0]  ow;
  logic [WGT_W-1:0]  nw;
  logic [EIDX_W-1:0] eaddr;
  logic [ECNT_W-1:0] stored;
  logic [DEG_W-1:0]  d0;
  logic [DEG_W-1:0]  d1;
  logic [DEG_W-1:0]  n0;
  logic [DEG_W-1:0]  n1;
  logic [1:0]        step;
  logic [SWP_W-1:0]  sweep;
  logic              clr_pend;
  logic [MAX_VERTICES-1:0] valid;
  logic              valid_a_q;
  logic              valid_b_q;

  logic [EIDX_W-1:0] scan_idx;
  logic              p1_vld;
  logic              p2_vld;
  logic              p3_vld;
  logic              p4_vld;
  logic [EIDX_W-1:0] p1_idx;
  logic [EIDX_W-1:0] p2_idx;
  logic [EIDX_W-1:0] p3_idx;
  logic [EIDX_W-1:0] p4_idx;
  logic              p3_eq;
  logic [PRI_W-1:0]  p4_pri;
  logic [EIDX_W-1:0] best_idx;
  logic [PRI_W-1:0]  best_pri;
  status_t           status_r;
  logic [WGT_W-1:0]  old_w_r;

  edge_t             e_rd;
  edge_t             e_wdata;
  logic              e_we;
  logic [EIDX_W-1:0] e_raddr;

  logic              use_edge;
  logic [VTX_W-1:0]  deg_raddr_a;
  logic [VTX_W-1:0]  deg_raddr_b;
  logic [DEG_W-1:0]  deg_rd_a;
  logic [DEG_W-1:0]  deg_rd_b;
  logic [DEG_W-1:0]  dega;
  logic [DEG_W-1:0]  degb;
  logic              deg_we;
  logic [VTX_W-1:0]  deg_waddr;
  logic [DEG_W-1:0]  deg_wdata;

  logic [SUM_W-1:0]  n0_full;
  logic [SUM_W-1:0]  n1_full;
  logic              deg_over;
  logic              err;

  logic [DEG_W-1:0]  step_addr;
  logic [DEG_W-1:0]  bkt_raddr_a;
  logic [BCNT_W-1:0] ca;
  logic [BCNT_W-1:0] cb;
  logic              bkt_we;
  logic [DEG_W-1:0]  bkt_waddr;
  logic [BCNT_W-1:0] bkt_wdata;
  logic [2*BCNT_W-1:0] prod;

  assign in_a  = in_data[VTX_W-1:0];
  assign in_b  = in_data[2*VTX_W-1:VTX_W];
  assign in_ei = in_data[2*VTX_W+EIDX_W-1:2*VTX_W];
  assign in_w  = in_data[2*VTX_W+EIDX_W+WGT_W-1:2*VTX_W+EIDX_W];

  always_comb begin
    if (vertex_count == '0) begin
      n_new = VCNT_W'(1);
    end else if (vertex_count > VCNT_W'(MAX_VERTICES)) begin
      n_new = VCNT_W'(MAX_VERTICES);
    end else begin
      n_new = vertex_count;
    end
  end

  // Edge table.
  assign e_wdata = '{weight: nw, second: v1, first: v0};
  assign e_raddr = cmd.scan_issue ? scan_idx : eaddr;

  wdep_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (eaddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rd)
  );

  // Vertex degrees, two copies so both endpoints are read in the same cycle.
  assign use_edge    = p1_vld || (cmd.vtx_rd && (func_r == FUNC_ADJUST));
  assign deg_raddr_a = cmd.clr_rd ? sweep[VTX_W-1:0] : (use_edge ? e_rd.first : v0);
  assign deg_raddr_b = use_edge ? e_rd.second : v1;
  assign deg_we      = cmd.bkt_wr && step[0];
  assign deg_waddr   = step[1] ? v1 : v0;
  assign deg_wdata   = step[1] ? n1 : n0;

  wdep_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg_ram_a (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr_a),
    .rdata (deg_rd_a)
  );

  wdep_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg_ram_b (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr_b),
    .rdata (deg_rd_b)
  );

  // A vertex not written since the last clear has degree zero.
  assign dega = valid_a_q ? deg_rd_a : '0;
  assign degb = valid_b_q ? deg_rd_b : '0;

  // Degree bucket counts, two copies for the two endpoints of a scanned edge.
  always_comb begin
    unique case (step)
      2'd0:    step_addr = d0;
      2'd1:    step_addr = n0;
      2'd2:    step_addr = d1;
      2'd3:    step_addr = n1;
      default: step_addr = d0;
    endcase
  end

  assign bkt_raddr_a = cmd.bkt_rd ? step_addr : dega;

  always_comb begin
    bkt_we    = 1'b1;
    bkt_waddr = step_addr;
    bkt_wdata = '0;
    priority if (cmd.init_wr) begin
      bkt_waddr = sweep;
      bkt_wdata = (sweep == '0) ? active : '0;
    end else if (clr_pend) begin
      bkt_waddr = dega;
    end else if (cmd.clr_fin) begin
      bkt_waddr = '0;
      bkt_wdata = n_new;
    end else if (cmd.bkt_wr) begin
      bkt_wdata = step[0] ? (ca + BCNT_W'(1)) : (ca - BCNT_W'(1));
    end else begin
      bkt_we = 1'b0;
    end
  end

  wdep_ram #(.WIDTH(BCNT_W), .DEPTH(BKT_DEPTH)) u_bkt_ram_a (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bkt_raddr_a),
    .rdata (ca)
  );

  wdep_ram #(.WIDTH(BCNT_W), .DEPTH(BKT_DEPTH)) u_bkt_ram_b (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (degb),
    .rdata (cb)
  );

  // New endpoint degrees and range checks of an add or an adjust.
  assign n0_full  = SUM_W'(dega) + SUM_W'(nw) - SUM_W'(ow);
  assign n1_full  = SUM_W'(degb) + SUM_W'(nw) - SUM_W'(ow);
  assign deg_over = (n0_full > SUM_W'(MAX_DEGREE)) || (n1_full > SUM_W'(MAX_DEGREE));

  always_comb begin
    if (func_r == FUNC_ADD) begin
      err = (VCNT_W'(v0) >= active) || (VCNT_W'(v1) >= active) || (v0 == v1) ||
            (stored >= ECNT_W'(MAX_EDGES)) || deg_over;
    end else begin
      err = (ECNT_W'(eaddr) >= stored) || (nw > WGT_W'(MAX_WEIGHT)) || deg_over;
    end
  end

  assign e_we = cmd.check && !err && (ow != nw);
  assign prod = ca * cb;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCNT_W'(VCNT_RESET);
      active       <= VCNT_W'(VCNT_RESET);
      stored       <= '0;
      sweep        <= '0;
      clr_pend     <= 1'b0;
      valid        <= '0;
      p1_vld       <= 1'b0;
      p2_vld       <= 1'b0;
      p3_vld       <= 1'b0;
      p4_vld       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        vertex_count <= cfg_data;
      end
      if (cmd.accept) begin
        sweep <= '0;
      end else if (cmd.init_wr || cmd.clr_rd) begin
        sweep <= sweep + SWP_W'(1);
      end
      clr_pend <= cmd.clr_rd;
      if (cmd.clr_fin) begin
        active <= n_new;
        stored <= '0;
        valid  <= '0;
      end else begin
        if (e_we && (func_r == FUNC_ADD)) begin
          stored <= stored + ECNT_W'(1);
        end
        if (deg_we) begin
          valid[deg_waddr] <= 1'b1;
        end
      end
      p1_vld <= cmd.scan_issue;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
      if (cmd.done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    valid_a_q <= valid[deg_raddr_a];
    valid_b_q <= valid[deg_raddr_b];
    if (cmd.accept) begin
      func_r   <= in_func;
      v0       <= in_a;
      v1       <= in_b;
      ow       <= '0;
      nw       <= (in_func == FUNC_ADD) ? WGT_W'(1) : in_w;
      eaddr    <= (in_func == FUNC_ADD) ? stored[EIDX_W-1:0] : in_ei;
      scan_idx <= '0;
      best_idx <= '0;
      best_pri <= '0;
      old_w_r  <= '0;
      status_r <= ((in_func == FUNC_SELECT) && (stored == '0)) ? STATUS_EMPTY : STATUS_OK;
    end
    if (cmd.vtx_rd && (func_r == FUNC_ADJUST)) begin
      v0 <= e_rd.first;
      v1 <= e_rd.second;
      ow <= e_rd.weight;
    end
    if (cmd.check) begin
      d0   <= dega;
      d1   <= degb;
      n0   <= n0_full[DEG_W-1:0];
      n1   <= n1_full[DEG_W-1:0];
      step <= '0;
      if (err) begin
        status_r <= STATUS_RANGE;
      end else begin
        old_w_r <= ow;
      end
    end
    if (cmd.bkt_wr) begin
      step <= step + 2'd1;
    end
    if (cmd.scan_issue) begin
      scan_idx <= scan_idx + EIDX_W'(1);
    end
    p1_idx <= scan_idx;
    p2_idx <= p1_idx;
    p3_idx <= p2_idx;
    p4_idx <= p3_idx;
    p3_eq  <= (dega == degb);
    p4_pri <= p3_eq ? '0 : prod[PRI_W-1:0];
    if (p4_vld && (p4_pri >= best_pri)) begin
      best_pri <= p4_pri;
      best_idx <= p4_idx;
    end
    if (cmd.done) begin
      out_status <= status_r;
      out_data   <= {PAD_W'(0), best_pri, best_idx, old_w_r};
    end
  end

  assign stat.init_last = (sweep == SWP_W'(BKT_DEPTH - 1));
  assign stat.clr_last  = (sweep[VTX_W-1:0] == VTX_W'(MAX_VERTICES - 1));
  assign stat.err       = err;
  assign stat.no_change = (ow == nw);
  assign stat.step_last = (step == 2'd3);
  assign stat.sel_empty = (stored == '0);
  assign stat.scan_last = (ECNT_W'(scan_idx) == (stored - ECNT_W'(1)));
  assign stat.scan_busy = p1_vld || p2_vld || p3_vld || p4_vld;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

### hw/rtl/weighted_degree_edge_priority.sv
// An adjust reads the edge; an add or adjust reads both degrees, checks, and if accepted
// and changed updates the bucket counts. A clear sweeps every vertex slot, a select each edge.
// The block takes one word at a time; a select scans the edge table at one edge per cycle.
// The next word is taken the cycle after a result is loaded, even if it is not yet taken.
// After rst every entry of the bucket count memory is written with the input held off;
// configuration writes are taken during that time. rst is synchronous and active high.
module weighted_degree_edge_priority (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,       // vertex_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // endpoint_a, endpoint_b, edge_idx, weight, zero pad
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // prev_weight, best_edge, best_priority, zero pad
  output logic [1:0]  m_axis_tuser    // status
);

  import wdep_pkg::*;

  wdep_cmd_t  cmd;
  wdep_stat_t stat;
  func_t      in_func;

  assign cfg_ready = 1'b1;
  assign in_func   = func_t'(s_axis_tuser);

  wdep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (in_func),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  wdep_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_func    (in_func),
    .in_data    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_data   (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted again while a word is in progress");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.init_wr, cmd.clr_rd, cmd.clr_fin, cmd.vtx_rd,
              cmd.check, cmd.bkt_rd, cmd.bkt_wr, cmd.scan_issue, cmd.done}))
    else $error("controller issued overlapping commands");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    cmd.done |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_EMPTY ||
                       m_axis_tuser == STATUS_RANGE))
    else $error("result carries an undefined status code");
`endif

endmodule
